// ----- rtl/sin_pkg.sv -----
// Shared constants for the segment intersection / wall normal pipeline.
// No dependencies.
`default_nettype none
package sin_pkg;
    localparam int NORM_STEPS = 15;
    localparam int NORM_W     = 16;
    localparam int TGT_SHIFT  = 30;
    localparam int SQ_W       = 32;
    localparam int O2_W       = 33;
endpackage
`default_nettype wire

// ----- rtl/sin_front.sv -----
// Front end: differences, products, crossing ratio and projection tests.
// Six register stages advanced by a common enable; depends on nothing else.
`default_nettype none
module sin_front #(
    parameter int C = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [C-1:0]  p1x,
    input  wire logic signed [C-1:0]  p1y,
    input  wire logic signed [C-1:0]  p2x,
    input  wire logic signed [C-1:0]  p2y,
    input  wire logic signed [C-1:0]  ax,
    input  wire logic signed [C-1:0]  ay,
    input  wire logic signed [C-1:0]  bx,
    input  wire logic signed [C-1:0]  by,
    output logic                      out_valid,
    output logic                      hit,
    output logic [2*C+1:0]            den,
    output logic [3*C+1:0]            prod_x,
    output logic [3*C+1:0]            prod_y,
    output logic [4*C+3:0]            side,
    output logic [2*C:0]              len2,
    output logic [2*C-1:0]            sq_nx,
    output logic [2*C-1:0]            sq_ny
);
    localparam int D  = C + 1;
    localparam int P  = 2 * C + 2;
    localparam int W  = 2 * C + 3;
    localparam int PW = 3 * C + 2;
    localparam int SW = 4 * C + 7;
    localparam int SD = 4 * C + 4;

    // stage 1
    logic                v1_reg;
    logic signed [D-1:0] dx1_reg, dy1_reg, ex1_reg, ey1_reg, px1_reg, py1_reg;
    logic [2*C-1:0]      base1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg   <= D'(p2x) - D'(p1x);
            dy1_reg   <= D'(p2y) - D'(p1y);
            ex1_reg   <= D'(bx) - D'(ax);
            ey1_reg   <= D'(by) - D'(ay);
            px1_reg   <= D'(p1x) - D'(ax);
            py1_reg   <= D'(p1y) - D'(ay);
            base1_reg <= {p1x, p1y};
        end
    end

    // stage 2: all products
    logic                v2_reg;
    logic signed [P-1:0] dyex_reg, dxey_reg, pxey_reg, pyex_reg;
    logic signed [P-1:0] pxex_reg, pyey_reg, dxex_reg, dyey_reg, exex_reg, eyey_reg;
    logic [SD-1:0]       side2_reg;
    logic [C-1:0]        absdx, absdy;

    assign absdx = dx1_reg[D-1] ? C'(-dx1_reg) : C'(dx1_reg);
    assign absdy = dy1_reg[D-1] ? C'(-dy1_reg) : C'(dy1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dyex_reg  <= P'(dy1_reg) * P'(ex1_reg);
            dxey_reg  <= P'(dx1_reg) * P'(ey1_reg);
            pxey_reg  <= P'(px1_reg) * P'(ey1_reg);
            pyex_reg  <= P'(py1_reg) * P'(ex1_reg);
            pxex_reg  <= P'(px1_reg) * P'(ex1_reg);
            pyey_reg  <= P'(py1_reg) * P'(ey1_reg);
            dxex_reg  <= P'(dx1_reg) * P'(ex1_reg);
            dyey_reg  <= P'(dy1_reg) * P'(ey1_reg);
            exex_reg  <= P'(ex1_reg) * P'(ex1_reg);
            eyey_reg  <= P'(ey1_reg) * P'(ey1_reg);
            // normal_x sign follows -ey, normal_y sign follows ex
            side2_reg <= {base1_reg, absdx, absdy, dx1_reg[D-1], dy1_reg[D-1],
                          ~ey1_reg[D-1], ex1_reg[D-1]};
        end
    end

    // stage 3: sums
    logic                v3_reg;
    logic signed [W-1:0] den3_reg, num3_reg, t3_reg, u3_reg, len3_reg;
    logic [2*C-1:0]      sqnx3_reg, sqny3_reg;
    logic [SD-1:0]       side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den3_reg  <= W'(dyex_reg) - W'(dxey_reg);
            num3_reg  <= W'(pxey_reg) - W'(pyex_reg);
            t3_reg    <= W'(pxex_reg) + W'(pyey_reg);
            u3_reg    <= W'(dxex_reg) + W'(dyey_reg);
            len3_reg  <= W'(exex_reg) + W'(eyey_reg);
            sqnx3_reg <= eyey_reg[2*C-1:0];
            sqny3_reg <= exex_reg[2*C-1:0];
            side3_reg <= side2_reg;
        end
    end

    // stage 4: sign normalize, ratio range test
    logic                v4_reg, ok4_reg;
    logic signed [W-1:0] den4_reg, num4_reg, t4_reg, u4_reg, len4_reg;
    logic [2*C-1:0]      sqnx4_reg, sqny4_reg;
    logic [SD-1:0]       side4_reg;
    logic signed [W-1:0] denp, nump;

    assign denp = den3_reg[W-1] ? -den3_reg : den3_reg;
    assign nump = den3_reg[W-1] ? -num3_reg : num3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok4_reg   <= (den3_reg != '0) && !nump[W-1] && (nump <= denp);
            den4_reg  <= denp;
            num4_reg  <= nump;
            t4_reg    <= t3_reg;
            u4_reg    <= u3_reg;
            len4_reg  <= len3_reg;
            sqnx4_reg <= sqnx3_reg;
            sqny4_reg <= sqny3_reg;
            side4_reg <= side3_reg;
        end
    end

    // stage 5: wide products
    logic                 v5_reg, ok5_reg;
    logic signed [SW-1:0] td5_reg, nu5_reg, ld5_reg;
    logic [PW-1:0]        prx5_reg, pry5_reg;
    logic [W-2:0]         den5_reg;
    logic [2*C:0]         len5_reg;
    logic [2*C-1:0]       sqnx5_reg, sqny5_reg;
    logic [SD-1:0]        side5_reg;
    logic [C-1:0]         mdx, mdy;

    assign mdx = side4_reg[2*C+3:C+4];
    assign mdy = side4_reg[C+3:4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok5_reg   <= ok4_reg;
            td5_reg   <= SW'(t4_reg) * SW'(den4_reg);
            nu5_reg   <= SW'(num4_reg) * SW'(u4_reg);
            ld5_reg   <= SW'(len4_reg) * SW'(den4_reg);
            prx5_reg  <= PW'(num4_reg[W-2:0]) * PW'(mdx);
            pry5_reg  <= PW'(num4_reg[W-2:0]) * PW'(mdy);
            den5_reg  <= den4_reg[W-2:0];
            len5_reg  <= len4_reg[2*C:0];
            sqnx5_reg <= sqnx4_reg;
            sqny5_reg <= sqny4_reg;
            side5_reg <= side4_reg;
        end
    end

    // stage 6: projection test
    logic                 v6_reg, hit6_reg;
    logic [W-2:0]         den6_reg;
    logic [PW-1:0]        prx6_reg, pry6_reg;
    logic [2*C:0]         len6_reg;
    logic [2*C-1:0]       sqnx6_reg, sqny6_reg;
    logic [SD-1:0]        side6_reg;
    logic signed [SW-1:0] s_sum;

    assign s_sum = td5_reg + nu5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit6_reg  <= ok5_reg && !s_sum[SW-1] && (s_sum <= ld5_reg);
            den6_reg  <= den5_reg;
            prx6_reg  <= prx5_reg;
            pry6_reg  <= pry5_reg;
            len6_reg  <= len5_reg;
            sqnx6_reg <= sqnx5_reg;
            sqny6_reg <= sqny5_reg;
            side6_reg <= side5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign hit       = hit6_reg;
    assign den       = den6_reg;
    assign prod_x    = prx6_reg;
    assign prod_y    = pry6_reg;
    assign side      = side6_reg;
    assign len2      = len6_reg;
    assign sq_nx     = sqnx6_reg;
    assign sq_ny     = sqny6_reg;
endmodule
`default_nettype wire

// ----- rtl/sin_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, both axes at once.
// Final stage rounds half up and offsets from the segment start; no dependencies.
`default_nettype none
module sin_div #(
    parameter int C  = 16,
    parameter int CW = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [2*C+1:0]       den,
    input  wire logic [3*C+1:0]       prod_x,
    input  wire logic [3*C+1:0]       prod_y,
    input  wire logic signed [C-1:0]  base_x,
    input  wire logic signed [C-1:0]  base_y,
    input  wire logic                 neg_x,
    input  wire logic                 neg_y,
    input  wire logic [CW-1:0]        ctx_in,
    output logic                      out_valid,
    output logic signed [C-1:0]       cross_x,
    output logic signed [C-1:0]       cross_y,
    output logic [CW-1:0]             ctx_out
);
    localparam int DW = 2 * C + 2;
    localparam int PW = 3 * C + 2;
    localparam int KW = 2 * C + 2 + CW;

    logic          v_reg   [0:C-1];
    logic [DW-1:0] den_reg [0:C-1];
    logic [PW-1:0] rx_reg  [0:C-1];
    logic [PW-1:0] ry_reg  [0:C-1];
    logic [C-1:0]  qx_reg  [0:C-1];
    logic [C-1:0]  qy_reg  [0:C-1];
    logic [KW-1:0] k_reg   [0:C-1];

    for (genvar k = 0; k < C; k++) begin : g_step
        logic          v_in;
        logic [DW-1:0] d_in;
        logic [PW-1:0] rx_in, ry_in, dsh, rx_next, ry_next;
        logic [C-1:0]  qx_in, qy_in, qx_next, qy_next, bitv;
        logic [KW-1:0] k_in;

        if (k == 0) begin : g_first
            assign v_in  = in_valid;
            assign d_in  = den;
            assign rx_in = prod_x;
            assign ry_in = prod_y;
            assign qx_in = '0;
            assign qy_in = '0;
            assign k_in  = {base_x, base_y, neg_x, neg_y, ctx_in};
        end else begin : g_rest
            assign v_in  = v_reg[k-1];
            assign d_in  = den_reg[k-1];
            assign rx_in = rx_reg[k-1];
            assign ry_in = ry_reg[k-1];
            assign qx_in = qx_reg[k-1];
            assign qy_in = qy_reg[k-1];
            assign k_in  = k_reg[k-1];
        end

        assign dsh     = PW'(d_in) << (C - 1 - k);
        assign bitv    = C'(1) << (C - 1 - k);
        assign rx_next = (rx_in >= dsh) ? rx_in - dsh : rx_in;
        assign ry_next = (ry_in >= dsh) ? ry_in - dsh : ry_in;
        assign qx_next = (rx_in >= dsh) ? (qx_in | bitv) : qx_in;
        assign qy_next = (ry_in >= dsh) ? (qy_in | bitv) : qy_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= d_in;
                rx_reg[k]  <= rx_next;
                ry_reg[k]  <= ry_next;
                qx_reg[k]  <= qx_next;
                qy_reg[k]  <= qy_next;
                k_reg[k]   <= k_in;
            end
        end
    end

    // rounding and offset
    logic                v_out_reg;
    logic signed [C-1:0] cx_reg, cy_reg;
    logic [CW-1:0]       ctx_reg;
    logic [KW-1:0]       kl;
    logic [C:0]          mag_x, mag_y;
    logic signed [C:0]   sx, sy;
    logic                upx, upy;

    assign kl    = k_reg[C-1];
    assign upx   = ((PW+1)'(rx_reg[C-1]) << 1) >= (PW+1)'(den_reg[C-1]);
    assign upy   = ((PW+1)'(ry_reg[C-1]) << 1) >= (PW+1)'(den_reg[C-1]);
    assign mag_x = (C+1)'(qx_reg[C-1]) + (C+1)'(upx);
    assign mag_y = (C+1)'(qy_reg[C-1]) + (C+1)'(upy);
    assign sx    = (C+1)'($signed(kl[KW-1:KW-C]))
                   + (kl[CW+1] ? -$signed(mag_x) : $signed(mag_x));
    assign sy    = (C+1)'($signed(kl[KW-C-1:CW+2]))
                   + (kl[CW] ? -$signed(mag_y) : $signed(mag_y));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out_reg <= 1'b0;
        end else if (en) begin
            v_out_reg <= v_reg[C-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg  <= sx[C-1:0];
            cy_reg  <= sy[C-1:0];
            ctx_reg <= kl[CW-1:0];
        end
    end

    assign out_valid = v_out_reg;
    assign cross_x   = cx_reg;
    assign cross_y   = cy_reg;
    assign ctx_out   = ctx_reg;
endmodule
`default_nettype wire

// ----- rtl/sin_norm.sv -----
// Pipelined Q2.14 unit normal: one result bit per stage, compared against sq_n << 30.
// Depends on sin_pkg.
`default_nettype none
module sin_norm #(
    parameter int C  = 16,
    parameter int CW = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [2*C:0]                  len2,
    input  wire logic [2*C-1:0]                sq_nx,
    input  wire logic [2*C-1:0]                sq_ny,
    input  wire logic                          neg_nx,
    input  wire logic                          neg_ny,
    input  wire logic [CW-1:0]                 ctx_in,
    output logic                               out_valid,
    output logic signed [sin_pkg::NORM_W-1:0]  normal_x,
    output logic signed [sin_pkg::NORM_W-1:0]  normal_y,
    output logic [CW-1:0]                      ctx_out
);
    localparam int N   = sin_pkg::NORM_STEPS;
    localparam int SQW = sin_pkg::SQ_W;
    localparam int OW  = sin_pkg::O2_W;
    localparam int LW  = 2 * C + 1;
    localparam int MW  = OW + LW;
    localparam int KW  = 4 * C + 2 + CW;

    logic           v_reg  [0:N-1];
    logic [LW-1:0]  l_reg  [0:N-1];
    logic [N-1:0]   rx_reg [0:N-1];
    logic [N-1:0]   ry_reg [0:N-1];
    logic [SQW-1:0] qx_reg [0:N-1];
    logic [SQW-1:0] qy_reg [0:N-1];
    logic [KW-1:0]  k_reg  [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam int B = N - 1 - k;
        logic           v_in;
        logic [LW-1:0]  l_in;
        logic [N-1:0]   rx_in, ry_in, cx, cy;
        logic [SQW-1:0] qx_in, qy_in, sqcx, sqcy;
        logic [KW-1:0]  k_in;
        logic [OW-1:0]  ox, oy;
        logic [MW-1:0]  lhx, lhy, tgx, tgy;
        logic           okx, oky;

        if (k == 0) begin : g_first
            assign v_in  = in_valid;
            assign l_in  = len2;
            assign rx_in = '0;
            assign ry_in = '0;
            assign qx_in = '0;
            assign qy_in = '0;
            assign k_in  = {sq_nx, sq_ny, neg_nx, neg_ny, ctx_in};
        end else begin : g_rest
            assign v_in  = v_reg[k-1];
            assign l_in  = l_reg[k-1];
            assign rx_in = rx_reg[k-1];
            assign ry_in = ry_reg[k-1];
            assign qx_in = qx_reg[k-1];
            assign qy_in = qy_reg[k-1];
            assign k_in  = k_reg[k-1];
        end

        // (r + 2^B)^2 = r^2 + r*2^(B+1) + 2^(2B)
        assign cx   = rx_in | (N'(1) << B);
        assign cy   = ry_in | (N'(1) << B);
        assign sqcx = qx_in + (SQW'(rx_in) << (B + 1)) + (SQW'(1) << (2 * B));
        assign sqcy = qy_in + (SQW'(ry_in) << (B + 1)) + (SQW'(1) << (2 * B));
        assign ox   = (OW'(sqcx) << 2) - (OW'(cx) << 2) + OW'(1);
        assign oy   = (OW'(sqcy) << 2) - (OW'(cy) << 2) + OW'(1);
        assign lhx  = MW'(ox) * MW'(l_in);
        assign lhy  = MW'(oy) * MW'(l_in);
        assign tgx  = MW'(k_in[KW-1:KW-2*C]) << sin_pkg::TGT_SHIFT;
        assign tgy  = MW'(k_in[KW-2*C-1:CW+2]) << sin_pkg::TGT_SHIFT;
        assign okx  = lhx <= tgx;
        assign oky  = lhy <= tgy;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                l_reg[k]  <= l_in;
                rx_reg[k] <= okx ? cx : rx_in;
                ry_reg[k] <= oky ? cy : ry_in;
                qx_reg[k] <= okx ? sqcx : qx_in;
                qy_reg[k] <= oky ? sqcy : qy_in;
                k_reg[k]  <= k_in;
            end
        end
    end

    logic [KW-1:0]                  kl;
    logic [sin_pkg::NORM_W-1:0]     mx, my;

    assign kl        = k_reg[N-1];
    assign mx        = sin_pkg::NORM_W'(rx_reg[N-1]);
    assign my        = sin_pkg::NORM_W'(ry_reg[N-1]);
    assign out_valid = v_reg[N-1];
    assign normal_x  = kl[CW+1] ? -$signed(mx) : $signed(mx);
    assign normal_y  = kl[CW] ? -$signed(my) : $signed(my);
    assign ctx_out   = kl[CW-1:0];
endmodule
`default_nettype wire

// ----- rtl/segment_intersection_normal.sv -----
// Moving segment versus wall segment hit test with crossing point and unit normal.
// Top level; depends on sin_pkg, sin_front, sin_div and sin_norm.
//
// Input beats on s_* carry P1, P2, A, B as signed coordinates (COORD_BITS each).
// Output beats on m_* carry the hit flag in m_tuser and the crossing point plus
// the Q2.14 unit wall normal in m_tdata; with no hit every field is zero.
// One result beat per input beat, in order.
// Throughput: one beat per cycle while m_tready does not hold the output. The
// pipeline is made up of the six front stages, one divider stage per quotient
// bit plus a rounding stage, fifteen normal stages and the output register.
// The whole pipeline advances together; it holds while the output register is
// full and m_tready is low, and s_tready drops for that time. Empty slots in
// the pipeline do not hold it up.
// Reset (aresetn low, synchronous) clears all valid bits; data in flight is
// dropped.
`default_nettype none
module segment_intersection_normal #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // start_x, start_y, end_x, end_y, wall_a_x, wall_a_y, wall_b_x, wall_b_y
    input  wire logic [8*COORD_BITS-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // cross_x, cross_y, normal_x, normal_y, zero fill
    output logic [((2*COORD_BITS+2*sin_pkg::NORM_W+7)/8)*8-1:0] m_tdata,
    // hit
    output logic                                m_tuser
);
    localparam int C   = COORD_BITS;
    localparam int NW  = sin_pkg::NORM_W;
    localparam int OD  = ((2 * C + 2 * NW + 7) / 8) * 8;
    localparam int DCW = 6 * C + 4;
    localparam int NCW = 2 * C + 1;
    localparam int FQ  = (FRAC_BITS <= C) ? 1 : 0;

    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && (FQ == 1);

    logic                 f_valid, f_hit;
    logic [2*C+1:0]       f_den;
    logic [3*C+1:0]       f_px, f_py;
    logic [4*C+3:0]       f_side;
    logic [2*C:0]         f_len2;
    logic [2*C-1:0]       f_sqnx, f_sqny;

    sin_front #(.C(C)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid && s_tready),
        .p1x      (s_tdata[C-1:0]),
        .p1y      (s_tdata[2*C-1:C]),
        .p2x      (s_tdata[3*C-1:2*C]),
        .p2y      (s_tdata[4*C-1:3*C]),
        .ax       (s_tdata[5*C-1:4*C]),
        .ay       (s_tdata[6*C-1:5*C]),
        .bx       (s_tdata[7*C-1:6*C]),
        .by       (s_tdata[8*C-1:7*C]),
        .out_valid(f_valid),
        .hit      (f_hit),
        .den      (f_den),
        .prod_x   (f_px),
        .prod_y   (f_py),
        .side     (f_side),
        .len2     (f_len2),
        .sq_nx    (f_sqnx),
        .sq_ny    (f_sqny)
    );

    logic                d_valid;
    logic signed [C-1:0] d_cx, d_cy;
    logic [DCW-1:0]      d_ctx;

    sin_div #(.C(C), .CW(DCW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (f_valid),
        .den      (f_den),
        .prod_x   (f_px),
        .prod_y   (f_py),
        .base_x   (f_side[4*C+3:3*C+4]),
        .base_y   (f_side[3*C+3:2*C+4]),
        .neg_x    (f_side[3]),
        .neg_y    (f_side[2]),
        .ctx_in   ({f_hit, f_len2, f_sqnx, f_sqny, f_side[1], f_side[0]}),
        .out_valid(d_valid),
        .cross_x  (d_cx),
        .cross_y  (d_cy),
        .ctx_out  (d_ctx)
    );

    logic                 n_valid;
    logic signed [NW-1:0] n_nx, n_ny;
    logic [NCW-1:0]       n_ctx;

    sin_norm #(.C(C), .CW(NCW)) u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (d_valid),
        .len2     (d_ctx[6*C+2:4*C+2]),
        .sq_nx    (d_ctx[4*C+1:2*C+2]),
        .sq_ny    (d_ctx[2*C+1:2]),
        .neg_nx   (d_ctx[1]),
        .neg_ny   (d_ctx[0]),
        .ctx_in   ({d_ctx[DCW-1], d_cx, d_cy}),
        .out_valid(n_valid),
        .normal_x (n_nx),
        .normal_y (n_ny),
        .ctx_out  (n_ctx)
    );

    logic [OD-1:0] m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg;

    assign m_tdata_next = n_ctx[NCW-1]
        ? OD'({n_ny, n_nx, n_ctx[C-1:0], n_ctx[2*C-1:C]}) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= n_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= n_ctx[NCW-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule
`default_nettype wire
